/* design/circular_fifo_queue_defines.svh */
// Assertion helpers shared by the queue RTL.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef CIRCULAR_FIFO_QUEUE_DEFINES_SVH
`define CIRCULAR_FIFO_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define CFQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CFQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CFQ_ASSERT_IMP(lbl, ante, cons, msg)
`define CFQ_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* design/cfq_pkg.sv */
package cfq_pkg;

  // Queue geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Stream field widths
  localparam int MODE_W  = 3;
  localparam int ITEM_W  = 32;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND         = 3'd0,
    MODE_SERVE          = 3'd1,
    MODE_RETRIEVE       = 3'd2,
    MODE_SERVE_RETRIEVE = 3'd3,
    MODE_CLEAR          = 3'd4
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  // One access to the ring memory
  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [IDX_W-1:0]      waddr;
    logic [IDX_W-1:0]      raddr;
    logic [DATA_WIDTH-1:0] wdata;
  } ram_req_t;

  // Ring index advance with wrap
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(DEPTH - 1)) res = '0;
    else res = idx + IDX_W'(1);
    return res;
  endfunction

endpackage

/* design/cfq_ram.sv */
module cfq_ram (
  input  logic                            clk,
  input  cfq_pkg::ram_req_t               req,
  output logic [cfq_pkg::DATA_WIDTH-1:0]  rd_data_r
);
  import cfq_pkg::*;

  logic [DATA_WIDTH-1:0] ring_r [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      ring_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= ring_r[req.raddr];
    end
  end

endmodule

/* design/circular_fifo_queue.sv */
// Channel | Dir | Fields (tdata, low bit first)
// in_     | in  | mode[2:0], item_in[34:3], zero pad to 40 bits
// out_    | out | status[1:0], item_out[33:2], occupancy[38:34],
//         |     | is_empty[39], is_full[40], zero pad to 48 bits
//
// One item per cycle while the output is not stalled; each result passes through
// the read stage (control update plus ring read), then the output register.
// Append writes the ring in the accept cycle, so a following read sees it.
// rst_n clears count, head and tail (tail to DEPTH-1); ring contents are kept.
// A stalled output holds the read stage, which in turn holds in_tready low.
`include "circular_fifo_queue_defines.svh"

module circular_fifo_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cfq_pkg::IN_TDATA_W-1:0]     in_tdata,   // mode, item_in
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cfq_pkg::OUT_TDATA_W-1:0]    out_tdata   // status, item_out, occupancy,
                                                         // is_empty, is_full
);
  import cfq_pkg::*;

  // Queue control state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;

  // Read stage
  logic             s1_valid_r, s1_valid_nxt;
  status_t          s1_status_r, s1_status_nxt;
  logic             s1_rd_r, s1_rd_nxt;
  logic [CNT_W-1:0] s1_cnt_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [ITEM_W-1:0] out_item_r;
  logic [OCC_W-1:0]  out_occ_r;
  logic              out_empty_r;
  logic              out_full_r;

  logic                  accept;
  logic                  out_free;
  logic                  s1_go;
  mode_t                 mode;
  logic [DATA_WIDTH-1:0] wr_data;
  ram_req_t              ram_req;
  logic [DATA_WIDTH-1:0] rd_data;

  assign mode    = mode_t'(in_tdata[MODE_W-1:0]);
  assign wr_data = in_tdata[MODE_W +: DATA_WIDTH];

  // Handshake and stage advance
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign accept    = in_tvalid && in_tready;

  // Operation decode and index/count update
  always_comb begin
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    s1_status_nxt = STAT_OK;
    s1_rd_nxt     = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.re    = 1'b0;
    ram_req.waddr = next_slot(tail_r);
    ram_req.raddr = head_r;
    ram_req.wdata = wr_data;
    if (accept) begin
      unique case (mode)
        MODE_APPEND: begin
          if (cnt_r == CNT_W'(DEPTH)) begin
            s1_status_nxt = STAT_OVERFLOW;
          end else begin
            cnt_nxt    = cnt_r + CNT_W'(1);
            tail_nxt   = next_slot(tail_r);
            ram_req.we = 1'b1;
          end
        end
        MODE_SERVE, MODE_RETRIEVE, MODE_SERVE_RETRIEVE: begin
          if (cnt_r == '0) begin
            s1_status_nxt = STAT_UNDERFLOW;
          end else begin
            if (mode != MODE_SERVE) begin
              s1_rd_nxt  = 1'b1;
              ram_req.re = 1'b1;
            end
            if (mode != MODE_RETRIEVE) begin
              cnt_nxt  = cnt_r - CNT_W'(1);
              head_nxt = next_slot(head_r);
            end
          end
        end
        MODE_CLEAR: begin
          cnt_nxt  = '0;
          head_nxt = '0;
          tail_nxt = IDX_W'(DEPTH - 1);
        end
        default: begin
        end
      endcase
    end
  end

  cfq_ram u_ram (
    .clk       (clk),
    .req       (ram_req),
    .rd_data_r (rd_data)
  );

  // Valid tracking
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) s1_valid_nxt = 1'b1;
    else if (s1_go) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (s1_go) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      head_r      <= '0;
      tail_r      <= IDX_W'(DEPTH - 1);
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Read stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= s1_status_nxt;
      s1_rd_r     <= s1_rd_nxt;
      s1_cnt_r    <= cnt_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_status_r <= s1_status_r;
      out_item_r   <= s1_rd_r ? ITEM_W'(rd_data) : '0;
      out_occ_r    <= OCC_W'(s1_cnt_r);
      out_empty_r  <= (s1_cnt_r == '0);
      out_full_r   <= (s1_cnt_r == CNT_W'(DEPTH));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - STAT_W - ITEM_W - OCC_W - 2){1'b0}},
                       out_full_r, out_empty_r, out_occ_r, out_item_r, out_status_r};

  // Checks
  `CFQ_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CNT_W'(DEPTH), "count above depth")
  `CFQ_ASSERT_IMP(a_ovf_full, out_valid_r && out_status_r == STAT_OVERFLOW, out_full_r, "overflow while not full")
  `CFQ_ASSERT_IMP(a_udf_empty, out_valid_r && out_status_r == STAT_UNDERFLOW, out_empty_r, "underflow while not empty")
  `CFQ_ASSERT_IMP(a_err_zero, out_valid_r && out_status_r != STAT_OK, out_item_r == '0, "error result with data")
  `CFQ_ASSERT_NXT(a_s1_hold, s1_valid_r && !s1_go, s1_valid_r && $stable(s1_cnt_r), "read stage lost while stalled")

endmodule

/* verif/circular_fifo_queue_checker.sv */
// Watches both stream channels of the queue, keeps its own copy of the ring and
// compares every result item against the oldest predicted one.
module circular_fifo_queue_checker
  import cfq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // mode, item_in
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // status, item_out, occupancy,
                                             // is_empty, is_full
  output int                     mismatches,
  output int                     outstanding
);

  // Result item as the block reports it
  typedef struct {
    status_t             status;
    logic [ITEM_W-1:0]   item_out;
    logic [OCC_W-1:0]    occupancy;
    logic                is_empty;
    logic                is_full;
  } queue_result_t;

  // Shadow queue state
  logic [DATA_WIDTH-1:0] ring_copy [DEPTH];
  logic [CNT_W-1:0]      held;
  logic [IDX_W-1:0]      front;
  logic [IDX_W-1:0]      rear;

  queue_result_t awaited_results [$];
  int            bad_results = 0;

  assign mismatches = bad_results;
  initial outstanding = 0;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  // Apply one operation to the shadow state and return what the block should say
  function automatic queue_result_t apply_queue_op(input logic [MODE_W-1:0] mode,
                                                   input logic [ITEM_W-1:0] word);
    queue_result_t res;
    res.status   = STAT_OK;
    res.item_out = '0;
    case (mode)
      MODE_APPEND: begin
        if (held == CNT_W'(DEPTH)) begin
          res.status = STAT_OVERFLOW;
        end else begin
          held = held + CNT_W'(1);
          rear = wrap_inc(rear);
          ring_copy[rear] = word[DATA_WIDTH-1:0];
        end
      end
      MODE_SERVE, MODE_RETRIEVE, MODE_SERVE_RETRIEVE: begin
        if (held == '0) begin
          res.status = STAT_UNDERFLOW;
        end else begin
          if (mode != MODE_SERVE) res.item_out = ITEM_W'(ring_copy[front]);
          if (mode != MODE_RETRIEVE) begin
            held  = held - CNT_W'(1);
            front = wrap_inc(front);
          end
        end
      end
      MODE_CLEAR: begin
        held  = '0;
        front = '0;
        rear  = IDX_W'(DEPTH - 1);
      end
      default: ;  // unused codes leave the queue alone
    endcase
    res.occupancy = OCC_W'(held);
    res.is_empty  = (held == '0);
    res.is_full   = (held == CNT_W'(DEPTH));
    return res;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      bad_results++;
    end
  endtask

  // Track accepted items and results
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      held  = '0;
      front = '0;
      rear  = IDX_W'(DEPTH - 1);
      awaited_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        awaited_results.push_back(apply_queue_op(in_tdata[MODE_W-1:0],
                                                 in_tdata[MODE_W +: ITEM_W]));
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result item 0x%0h arrived with nothing expected", out_tdata);
          bad_results++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status",    64'(want.status),    64'(out_tdata[STAT_W-1:0]));
          check_field("item_out",  64'(want.item_out),  64'(out_tdata[STAT_W +: ITEM_W]));
          check_field("occupancy", 64'(want.occupancy),
                      64'(out_tdata[STAT_W+ITEM_W +: OCC_W]));
          check_field("is_empty",  64'(want.is_empty),
                      64'(out_tdata[STAT_W+ITEM_W+OCC_W]));
          check_field("is_full",   64'(want.is_full),
                      64'(out_tdata[STAT_W+ITEM_W+OCC_W+1]));
        end
      end
    end
    outstanding <= awaited_results.size();
  end

endmodule

/* verif/circular_fifo_queue_tb.sv */
// Drives queue operations into the block and a randomly stalling receiver on
// its output; the checker beside it does the prediction.
module circular_fifo_queue_tb;
  import cfq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI  = 3'd7;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS   = 342;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // mode, item_in
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // status, item_out, occupancy, is_empty, is_full

  int mismatches;
  int outstanding;
  int send_idle_pct = 18;
  int recv_idle_pct = 47;
  int quiet_cycles = 0;

  circular_fifo_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  circular_fifo_queue_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one item, with random gaps before it, and wait until it is taken
  task automatic push_item(input logic [MODE_W-1:0] mode, input logic [ITEM_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - MODE_W - ITEM_W){1'b0}}, word, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold the sender until every predicted result has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Alternating fill and drain runs so full and empty are hit often
  task automatic random_ops(input int count);
    int  run_left;
    bit  filling;
    int  pick;
    logic [MODE_W-1:0] mode;
    logic [ITEM_W-1:0] word;
    run_left = 0;
    filling  = 1'b0;
    repeat (count) begin
      if (run_left == 0) begin
        run_left = $urandom_range(40, 4);
        filling  = ~filling;
      end
      run_left--;
      pick = $urandom_range(99);
      if (pick < 2) mode = MODE_CLEAR;
      else if (pick < 4) mode = MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
      else if (pick < (filling ? 75 : 28)) mode = MODE_APPEND;
      else begin
        case ($urandom_range(2))
          0:       mode = MODE_SERVE;
          1:       mode = MODE_RETRIEVE;
          default: mode = MODE_SERVE_RETRIEVE;
        endcase
      end
      case ($urandom_range(15))
        0:       word = '0;
        1:       word = '1;
        default: word = $urandom;
      endcase
      push_item(mode, word);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reads and unused code on an empty queue
    push_item(MODE_SERVE, 32'h1234_5678);
    push_item(MODE_RETRIEVE, '0);
    push_item(MODE_SERVE_RETRIEVE, '1);
    push_item(MODE_UNUSED_HI, '1);
    // Fill to the top with extreme words, then one append too many
    push_item(MODE_APPEND, 32'hFFFF_FFFF);
    for (int i = 0; i < DEPTH - 1; i++)
      push_item(MODE_APPEND, i[0] ? 32'h5555_5555 : 32'hAAAA_AAAA);
    push_item(MODE_APPEND, 32'h0000_0000);
    push_item(MODE_UNUSED_MID, '0);
    push_item(MODE_RETRIEVE, '0);
    push_item(MODE_SERVE, '0);
    push_item(MODE_SERVE_RETRIEVE, '0);
    // Clear drops everything; a read after it underflows
    push_item(MODE_CLEAR, '1);
    push_item(MODE_RETRIEVE, '0);
    drain_results();

    // Sender light, receiver heavy idling; then the reverse, then no idling
    random_ops(PHASE_ITEMS);
    drain_results();
    send_idle_pct = 47;
    recv_idle_pct = 18;
    random_ops(PHASE_ITEMS);
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_ops(PHASE_ITEMS);
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
